### rtl/gqls_pkg.sv
// Shared types, register indexes and constants of the grid Q-learning step core.
`timescale 1ns / 1ps
`default_nettype none
package gqls_pkg;

   localparam int Q_W        = 24;
   localparam int NUM_ACT    = 4;
   localparam int ACT_W      = 2;
   localparam int REW_IN_W   = 8;
   localparam int FRAC_IN_W  = 16;
   localparam int EPI_CNT_W  = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_START_ROW   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_COL   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GOAL_ROW    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GOAL_COL    = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_GOAL_REWARD = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_WALL_REWARD = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_SHIFT = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_GAMMA_SHIFT = 4'd7;

   // register reset values
   localparam logic [1:0]        START_ROW_RST   = 2'd2;
   localparam logic [2:0]        START_COL_RST   = 3'd1;
   localparam logic [1:0]        GOAL_ROW_RST    = 2'd1;
   localparam logic [2:0]        GOAL_COL_RST    = 3'd4;
   localparam logic signed [7:0] GOAL_REWARD_RST = 8'sd8;
   localparam logic signed [7:0] WALL_REWARD_RST = -8'sd8;
   localparam logic [2:0]        ALPHA_SHIFT_RST = 3'd1;
   localparam logic [2:0]        GAMMA_SHIFT_RST = 3'd1;

   // action codes
   localparam logic [ACT_W-1:0] ACT_UP    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DOWN  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RIGHT = 2'd2;
   localparam logic [ACT_W-1:0] ACT_LEFT  = 2'd3;

   // episode end codes
   localparam logic [1:0] END_NONE = 2'd0;
   localparam logic [1:0] END_GOAL = 2'd1;
   localparam logic [1:0] END_WALL = 2'd2;

   localparam logic signed [Q_W-1:0] Q_MAX_C = 24'sh7FFFFF;
   localparam logic signed [Q_W-1:0] Q_MIN_C = -24'sh800000;

   typedef struct packed {
      logic [FRAC_IN_W-1:0] rand_fraction;
      logic [ACT_W-1:0]     rand_action;
   } req_payload_type;

   typedef struct packed {
      logic [ACT_W-1:0]        action_taken;
      logic                    explored;
      logic signed [7:0]       step_reward;
      logic signed [Q_W-1:0]   updated_q;
      logic [1:0]              agent_row_now;
      logic [2:0]              agent_col_now;
      logic [1:0]              episode_end;
      logic [EPI_CNT_W-1:0]    goals_reached;
      logic [EPI_CNT_W-1:0]    walls_hit;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_CUR,
      ST_MOVE,
      ST_READ_NXT,
      ST_UPDATE
   } gqls_state_type;

   typedef struct packed {
      logic capture;   // latch inputs, read current cell
      logic decide;    // visit count, explore test, greedy pick
      logic move;      // move agent, reward, read next cell
      logic target;    // best next Q, target value
      logic update;    // write Q, commit position, present result
   } gqls_cmd_type;

endpackage : gqls_pkg
`default_nettype wire

### rtl/gqls_ctrl.sv
// Step sequencer of the grid Q-learning step core.
`timescale 1ns / 1ps
`default_nettype none
module gqls_ctrl (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   output gqls_pkg::gqls_cmd_type cmd
);
   import gqls_pkg::*;

   gqls_state_type state_ff;
   gqls_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ_CUR;
            end
         end
         ST_READ_CUR: begin
            cmd.decide = 1'b1;
            state_in   = ST_MOVE;
         end
         ST_MOVE: begin
            cmd.move = 1'b1;
            state_in = ST_READ_NXT;
         end
         ST_READ_NXT: begin
            cmd.target = 1'b1;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule : gqls_ctrl
`default_nettype wire

### rtl/gqls_datapath.sv
// Datapath of the grid Q-learning step core: registers, Q and visit memories, arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module gqls_datapath #(
   parameter int GRID_ROWS   = 4,
   parameter int GRID_COLS   = 5,
   parameter int Q_FRAC_BITS = 8,
   parameter int VISIT_BITS  = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire gqls_pkg::gqls_cmd_type        cmd,
   input  wire gqls_pkg::req_payload_type     req_data,
   input  wire logic                          csr_we,
   input  wire logic [gqls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gqls_pkg::CSR_DATA_W-1:0] csr_wdata,
   output logic                               rsp_valid,
   output gqls_pkg::rsp_payload_type          rsp_data
);
   import gqls_pkg::*;

   localparam int NUM_CELLS = GRID_ROWS * GRID_COLS;
   localparam int CELL_W    = $clog2(NUM_CELLS);
   localparam int ROW_W     = $clog2(GRID_ROWS);
   localparam int COL_W     = $clog2(GRID_COLS);
   localparam int PROD_W    = FRAC_IN_W + VISIT_BITS;
   localparam int REW_W     = REW_IN_W + Q_FRAC_BITS;
   localparam int TGT_W     = ((REW_W > Q_W) ? REW_W : Q_W) + 1;
   localparam int DIF_W     = TGT_W + 1;
   localparam int NQ_W      = DIF_W + 1;
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(GRID_ROWS - 1);
   localparam logic [COL_W-1:0] COL_LAST = COL_W'(GRID_COLS - 1);

   typedef logic [NUM_ACT-1:0][Q_W-1:0] q_row_type;

   function automatic logic [ROW_W-1:0] clip_row(input logic [1:0] v);
      return (8'(v) > 8'(GRID_ROWS - 1)) ? ROW_LAST : ROW_W'(v);
   endfunction

   function automatic logic [COL_W-1:0] clip_col(input logic [2:0] v);
      return (8'(v) > 8'(GRID_COLS - 1)) ? COL_LAST : COL_W'(v);
   endfunction

   function automatic logic [CELL_W-1:0] cell_of(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
      return CELL_W'(int'(r) * GRID_COLS + int'(c));
   endfunction

   // configuration registers
   logic [1:0]        start_row_ff, goal_row_ff;
   logic [2:0]        start_col_ff, goal_col_ff;
   logic signed [7:0] goal_reward_ff, wall_reward_ff;
   logic [2:0]        alpha_shift_ff, gamma_shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_row_ff   <= START_ROW_RST;
         start_col_ff   <= START_COL_RST;
         goal_row_ff    <= GOAL_ROW_RST;
         goal_col_ff    <= GOAL_COL_RST;
         goal_reward_ff <= GOAL_REWARD_RST;
         wall_reward_ff <= WALL_REWARD_RST;
         alpha_shift_ff <= ALPHA_SHIFT_RST;
         gamma_shift_ff <= GAMMA_SHIFT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_START_ROW:   start_row_ff   <= csr_wdata[1:0];
            REG_START_COL:   start_col_ff   <= csr_wdata[2:0];
            REG_GOAL_ROW:    goal_row_ff    <= csr_wdata[1:0];
            REG_GOAL_COL:    goal_col_ff    <= csr_wdata[2:0];
            REG_GOAL_REWARD: goal_reward_ff <= $signed(csr_wdata);
            REG_WALL_REWARD: wall_reward_ff <= $signed(csr_wdata);
            REG_ALPHA_SHIFT: alpha_shift_ff <= csr_wdata[2:0];
            REG_GAMMA_SHIFT: gamma_shift_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // agent state and episode counters
   logic [ROW_W-1:0]     agent_row_ff, agent_row_in;
   logic [COL_W-1:0]     agent_col_ff, agent_col_in;
   logic [EPI_CNT_W-1:0] goal_cnt_ff, goal_cnt_in;
   logic [EPI_CNT_W-1:0] wall_cnt_ff, wall_cnt_in;

   // step registers
   logic [FRAC_IN_W-1:0]   frac_ff;
   logic [ACT_W-1:0]       ract_ff;
   logic [CELL_W-1:0]      cell_ff;
   q_row_type              cur_row_ff;
   logic                   explore_ff;
   logic [ACT_W-1:0]       greedy_ff;
   logic [ACT_W-1:0]       act_ff, act_in;
   logic [ROW_W-1:0]       nr_ff, nr_in;
   logic [COL_W-1:0]       nc_ff, nc_in;
   logic signed [7:0]      rew_ff, rew_in;
   logic [1:0]             end_ff, end_in;
   logic signed [TGT_W-1:0] target_ff, target_in;
   logic signed [Q_W-1:0]  q_cur_ff;

   // Q memory: one row of all actions per cell, valid bit per row
   q_row_type            q_mem [NUM_CELLS];
   logic [NUM_CELLS-1:0] q_valid_ff;
   q_row_type            q_rd_data_ff;
   logic                 q_rd_ok_ff;
   logic [CELL_W-1:0]    q_rd_addr;
   q_row_type            q_row;
   q_row_type            q_new_row;

   // visit memory, valid bit per cell
   logic [VISIT_BITS-1:0] visit_mem [NUM_CELLS];
   logic [NUM_CELLS-1:0]  visit_valid_ff;
   logic [VISIT_BITS-1:0] visit_rd_ff;
   logic                  visit_ok_ff;
   logic [VISIT_BITS-1:0] cnt;

   logic [CELL_W-1:0] cur_cell;
   logic signed [Q_W-1:0] nq_sat;

   assign cur_cell  = cell_of(agent_row_ff, agent_col_ff);
   assign q_rd_addr = cmd.capture ? cur_cell : cell_of(nr_in, nc_in);
   assign q_row     = q_rd_ok_ff ? q_rd_data_ff : '0;
   assign cnt       = visit_ok_ff ? visit_rd_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.capture || cmd.move) begin
         q_rd_data_ff <= q_mem[q_rd_addr];
      end
      if (cmd.update) begin
         q_mem[cell_ff] <= q_new_row;
      end
      if (cmd.capture) begin
         visit_rd_ff <= visit_mem[cur_cell];
      end
      if (cmd.decide) begin
         visit_mem[cell_ff] <= (&cnt) ? cnt : cnt + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff     <= '0;
         visit_valid_ff <= '0;
         q_rd_ok_ff     <= 1'b0;
         visit_ok_ff    <= 1'b0;
      end else begin
         if (cmd.capture || cmd.move) begin
            q_rd_ok_ff <= q_valid_ff[q_rd_addr];
         end
         if (cmd.capture) begin
            visit_ok_ff <= visit_valid_ff[cur_cell];
         end
         if (cmd.update) begin
            q_valid_ff[cell_ff] <= 1'b1;
         end
         if (cmd.decide) begin
            visit_valid_ff[cell_ff] <= 1'b1;
         end
      end
   end

   // decide: epsilon test and greedy pick over the current row
   logic [PROD_W-1:0] prod;
   logic              explore_in;
   logic [ACT_W-1:0]  greedy_in;

   assign prod       = PROD_W'(frac_ff) * PROD_W'(cnt);
   assign explore_in = (cnt == '0) || (prod[PROD_W-1:FRAC_IN_W] == '0);

   always_comb begin
      logic signed [Q_W-1:0] best;
      best      = $signed(q_row[0]);
      greedy_in = ACT_UP;
      for (int a = 1; a < NUM_ACT; a++) begin
         if ($signed(q_row[a]) > best) begin
            best      = $signed(q_row[a]);
            greedy_in = ACT_W'(a);
         end
      end
   end

   // move: saturating step, then goal before edge
   always_comb begin
      logic on_edge;
      logic at_goal;
      act_in = explore_ff ? ract_ff : greedy_ff;
      nr_in  = agent_row_ff;
      nc_in  = agent_col_ff;
      unique case (act_in)
         ACT_UP:    if (agent_row_ff != '0)      nr_in = agent_row_ff - 1'b1;
         ACT_DOWN:  if (agent_row_ff < ROW_LAST) nr_in = agent_row_ff + 1'b1;
         ACT_RIGHT: if (agent_col_ff < COL_LAST) nc_in = agent_col_ff + 1'b1;
         ACT_LEFT:  if (agent_col_ff != '0)      nc_in = agent_col_ff - 1'b1;
      endcase
      at_goal = (8'(nr_in) == 8'(goal_row_ff)) && (8'(nc_in) == 8'(goal_col_ff));
      on_edge = (nr_in == '0) || (nr_in == ROW_LAST) ||
                (nc_in == '0) || (nc_in == COL_LAST);
      if (at_goal) begin
         rew_in = goal_reward_ff;
         end_in = END_GOAL;
      end else if (on_edge) begin
         rew_in = wall_reward_ff;
         end_in = END_WALL;
      end else begin
         rew_in = '0;
         end_in = END_NONE;
      end
   end

   // target: reward plus discounted best Q of the next cell
   always_comb begin
      logic signed [Q_W-1:0]   best;
      logic signed [TGT_W-1:0] rew_ext;
      best = $signed(q_row[0]);
      for (int a = 1; a < NUM_ACT; a++) begin
         if ($signed(q_row[a]) > best) begin
            best = $signed(q_row[a]);
         end
      end
      rew_ext   = TGT_W'(rew_ff);
      target_in = (rew_ext <<< Q_FRAC_BITS) + TGT_W'(best >>> gamma_shift_ff);
   end

   // update: q + (target - q) >>> alpha, saturated
   always_comb begin
      logic signed [DIF_W-1:0] diff;
      logic signed [NQ_W-1:0]  nq;
      diff = DIF_W'(target_ff) - DIF_W'(q_cur_ff);
      nq   = NQ_W'(q_cur_ff) + NQ_W'(diff >>> alpha_shift_ff);
      if (nq > NQ_W'(Q_MAX_C)) begin
         nq_sat = Q_MAX_C;
      end else if (nq < NQ_W'(Q_MIN_C)) begin
         nq_sat = Q_MIN_C;
      end else begin
         nq_sat = Q_W'(nq);
      end
      q_new_row         = cur_row_ff;
      q_new_row[act_ff] = nq_sat;
   end

   always_comb begin
      agent_row_in = nr_ff;
      agent_col_in = nc_ff;
      goal_cnt_in  = goal_cnt_ff;
      wall_cnt_in  = wall_cnt_ff;
      if (end_ff != END_NONE) begin
         agent_row_in = clip_row(start_row_ff);
         agent_col_in = clip_col(start_col_ff);
      end
      if (end_ff == END_GOAL && !(&goal_cnt_ff)) begin
         goal_cnt_in = goal_cnt_ff + 1'b1;
      end
      if (end_ff == END_WALL && !(&wall_cnt_ff)) begin
         wall_cnt_in = wall_cnt_ff + 1'b1;
      end
   end

   rsp_payload_type rsp_in;
   rsp_payload_type rsp_data_ff;
   logic            rsp_valid_ff;

   always_comb begin
      rsp_in.action_taken  = act_ff;
      rsp_in.explored      = explore_ff;
      rsp_in.step_reward   = rew_ff;
      rsp_in.updated_q     = nq_sat;
      rsp_in.agent_row_now = 2'(agent_row_in);
      rsp_in.agent_col_now = 3'(agent_col_in);
      rsp_in.episode_end   = end_ff;
      rsp_in.goals_reached = goal_cnt_in;
      rsp_in.walls_hit     = wall_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         agent_row_ff <= clip_row(START_ROW_RST);
         agent_col_ff <= clip_col(START_COL_RST);
         goal_cnt_ff  <= '0;
         wall_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.update;
         if (cmd.update) begin
            agent_row_ff <= agent_row_in;
            agent_col_ff <= agent_col_in;
            goal_cnt_ff  <= goal_cnt_in;
            wall_cnt_ff  <= wall_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         frac_ff <= req_data.rand_fraction;
         ract_ff <= req_data.rand_action;
         cell_ff <= cur_cell;
      end
      if (cmd.decide) begin
         cur_row_ff <= q_row;
         explore_ff <= explore_in;
         greedy_ff  <= greedy_in;
      end
      if (cmd.move) begin
         act_ff <= act_in;
         nr_ff  <= nr_in;
         nc_ff  <= nc_in;
         rew_ff <= rew_in;
         end_ff <= end_in;
      end
      if (cmd.target) begin
         target_ff <= target_in;
         q_cur_ff  <= $signed(cur_row_ff[act_ff]);
      end
      if (cmd.update) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule : gqls_datapath
`default_nettype wire

### rtl/gridworld_q_learning_step_core.sv
// Top level of the grid Q-learning step core: sequencer plus datapath.
`timescale 1ns / 1ps
`default_nettype none
// A step runs through capture in idle, read current (decide), move, read next (target) and update;
//   the result strobe is registered from update. The next start is taken during the result strobe
//   cycle, as the core is idle again; a step holds two registered reads of the single-port Q row memory.
// The receiver cannot stall: rsp_valid is high for exactly one cycle per step.
// Reset (synchronous): registers to defaults, agent to the clipped start cell, counters to
//   zero; Q and visit stores read as zero through per-cell valid bits cleared at once.
module gridworld_q_learning_step_core #(
   parameter int GRID_ROWS   = 4,
   parameter int GRID_COLS   = 5,
   parameter int Q_FRAC_BITS = 8,
   parameter int VISIT_BITS  = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // step request
   input  wire logic                            start,
   output logic                                 busy,
   input  wire gqls_pkg::req_payload_type       req_data,
   // register writes
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [gqls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gqls_pkg::CSR_DATA_W-1:0] csr_wdata,
   // step result
   output logic                                 rsp_valid,
   output gqls_pkg::rsp_payload_type            rsp_data
);
   import gqls_pkg::*;

   gqls_cmd_type cmd;

   // Register writes always complete; the user must issue them only while the core is idle, unchecked.
   assign csr_ready = 1'b1;

   // Sequencer: idle, read current cell, move, read next cell, update.
   gqls_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // Datapath holds the registers, both stores and the Q update arithmetic.
   gqls_datapath #(
      .GRID_ROWS   (GRID_ROWS),
      .GRID_COLS   (GRID_COLS),
      .Q_FRAC_BITS (Q_FRAC_BITS),
      .VISIT_BITS  (VISIT_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule : gridworld_q_learning_step_core
`default_nettype wire

### rtl/gqls_checker.sv
// Port-level checks of the grid Q-learning step core and their bind.
`timescale 1ns / 1ps
`default_nettype none
module gqls_checker (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      start,
   input wire logic                      busy,
   input wire logic                      rsp_valid,
   input wire gqls_pkg::rsp_payload_type rsp_data
);
   import gqls_pkg::*;

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy after an accepted start");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held longer than one cycle");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result without a step in progress");

   a_end_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.episode_end == END_NONE ||
                     rsp_data.episode_end == END_GOAL ||
                     rsp_data.episode_end == END_WALL))
      else $error("invalid episode end code");

   a_reset_idle: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> (!busy && !rsp_valid))
      else $error("core not idle after reset");

endmodule : gqls_checker

bind gridworld_q_learning_step_core gqls_checker u_gqls_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire

### tb/gqls_step_checker.sv
// Checker for the grid Q-learning step core: predicts every step result and compares it.
`timescale 1ns / 1ps
module gqls_step_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic                            busy,
   input  wire gqls_pkg::req_payload_type       req_data,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [gqls_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gqls_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            rsp_valid,
   input  wire gqls_pkg::rsp_payload_type       rsp_data,
   output int                                   fail_count,
   output int                                   outstanding
);
   import gqls_pkg::*;

   localparam int ROWS  = 4;
   localparam int COLS  = 5;
   localparam int CELLS = ROWS * COLS;
   localparam int FRAC  = 8;
   localparam logic [15:0]          VISIT_SAT = 16'hFFFF;
   localparam logic [EPI_CNT_W-1:0] EPI_SAT   = '1;

   // shadow registers
   logic [1:0]        start_row, goal_row;
   logic [2:0]        start_col, goal_col;
   logic signed [7:0] goal_reward, wall_reward;
   logic [2:0]        alpha_sh, gamma_sh;

   // shadow learning state
   logic signed [Q_W-1:0] q_table [CELLS][NUM_ACT];
   logic [15:0]           visits [CELLS];
   logic [1:0]            row;
   logic [2:0]            col;
   logic [EPI_CNT_W-1:0]  goals, walls;

   rsp_payload_type predicted_steps [$];

   function automatic void return_to_start();
      row = (start_row > ROWS - 1) ? 2'(ROWS - 1) : start_row;
      col = (start_col > COLS - 1) ? 3'(COLS - 1) : start_col;
   endfunction

   task automatic clear_model();
      start_row   = START_ROW_RST;
      start_col   = START_COL_RST;
      goal_row    = GOAL_ROW_RST;
      goal_col    = GOAL_COL_RST;
      goal_reward = GOAL_REWARD_RST;
      wall_reward = WALL_REWARD_RST;
      alpha_sh    = ALPHA_SHIFT_RST;
      gamma_sh    = GAMMA_SHIFT_RST;
      for (int c = 0; c < CELLS; c++) begin
         visits[c] = '0;
         for (int a = 0; a < NUM_ACT; a++)
            q_table[c][a] = '0;
      end
      goals = '0;
      walls = '0;
      return_to_start();
   endtask

   // One learning step: epsilon-greedy pick, move, reward, Q update by shifts.
   function automatic rsp_payload_type learn_step(input req_payload_type stim);
      rsp_payload_type  res;
      int               cur_idx, ncell, nr, nc;
      logic [15:0]      cnt;
      logic             explore;
      logic [ACT_W-1:0] act;
      logic [1:0]       ending;
      longint           best, rew, q, target, nq;

      cur_idx = row * COLS + col;
      cnt     = visits[cur_idx];
      if (cnt != VISIT_SAT)
         visits[cur_idx] = cnt + 16'd1;

      // epsilon is 1/count; a zero count always explores
      explore = (cnt == 0) || (64'(stim.rand_fraction) * 64'(cnt) < 64'd65536);
      if (explore) begin
         act = stim.rand_action;
      end else begin
         act = ACT_UP;
         for (int a = 1; a < NUM_ACT; a++)
            if (q_table[cur_idx][a] > q_table[cur_idx][act])
               act = ACT_W'(a);
      end

      // moves off the grid stop at the edge
      nr = row;
      nc = col;
      case (act)
         ACT_UP:    if (nr > 0) nr--;
         ACT_DOWN:  if (nr < ROWS - 1) nr++;
         ACT_RIGHT: if (nc < COLS - 1) nc++;
         default:   if (nc > 0) nc--;
      endcase

      // goal wins over edge
      if (nr == goal_row && nc == goal_col) begin
         rew    = goal_reward;
         ending = END_GOAL;
      end else if (nr == 0 || nr == ROWS - 1 || nc == 0 || nc == COLS - 1) begin
         rew    = wall_reward;
         ending = END_WALL;
      end else begin
         rew    = 0;
         ending = END_NONE;
      end

      ncell = nr * COLS + nc;
      best  = q_table[ncell][0];
      for (int a = 1; a < NUM_ACT; a++)
         if (q_table[ncell][a] > best)
            best = q_table[ncell][a];

      q      = q_table[cur_idx][act];
      target = rew * (longint'(1) << FRAC) + (best >>> gamma_sh);
      nq     = q + ((target - q) >>> alpha_sh);
      if (nq > Q_MAX_C) nq = Q_MAX_C;
      if (nq < Q_MIN_C) nq = Q_MIN_C;
      q_table[cur_idx][act] = Q_W'(nq);

      row = 2'(nr);
      col = 3'(nc);
      if (ending == END_GOAL) begin
         if (goals != EPI_SAT) goals++;
         return_to_start();
      end else if (ending == END_WALL) begin
         if (walls != EPI_SAT) walls++;
         return_to_start();
      end

      res.action_taken  = act;
      res.explored      = explore;
      res.step_reward   = 8'(rew);
      res.updated_q     = Q_W'(nq);
      res.agent_row_now = row;
      res.agent_col_now = col;
      res.episode_end   = ending;
      res.goals_reached = goals;
      res.walls_hit     = walls;
      return res;
   endfunction

   task automatic check_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         clear_model();
         predicted_steps.delete();
      end else begin
         if (rsp_valid) begin
            if (predicted_steps.size() == 0) begin
               $error("step result with no request waiting");
               fail_count++;
            end else begin
               want = predicted_steps.pop_front();
               check_field("action_taken", want.action_taken, rsp_data.action_taken);
               check_field("explored", want.explored, rsp_data.explored);
               check_field("step_reward", $signed(want.step_reward),
                           $signed(rsp_data.step_reward));
               check_field("updated_q", $signed(want.updated_q),
                           $signed(rsp_data.updated_q));
               check_field("agent_row_now", want.agent_row_now, rsp_data.agent_row_now);
               check_field("agent_col_now", want.agent_col_now, rsp_data.agent_col_now);
               check_field("episode_end", want.episode_end, rsp_data.episode_end);
               check_field("goals_reached", want.goals_reached, rsp_data.goals_reached);
               check_field("walls_hit", want.walls_hit, rsp_data.walls_hit);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_START_ROW:   start_row   = csr_wdata[1:0];
               REG_START_COL:   start_col   = csr_wdata[2:0];
               REG_GOAL_ROW:    goal_row    = csr_wdata[1:0];
               REG_GOAL_COL:    goal_col    = csr_wdata[2:0];
               REG_GOAL_REWARD: goal_reward = csr_wdata;
               REG_WALL_REWARD: wall_reward = csr_wdata;
               REG_ALPHA_SHIFT: alpha_sh    = csr_wdata[2:0];
               REG_GAMMA_SHIFT: gamma_sh    = csr_wdata[2:0];
               default: ;
            endcase
         end
         if (start && !busy)
            predicted_steps.push_back(learn_step(req_data));
      end
      outstanding = predicted_steps.size();
   end

endmodule

### tb/testbench.sv
// Top of the grid Q-learning step core testbench: stimulus, register setup and verdict.
`timescale 1ns / 1ps
module testbench;
   import gqls_pkg::*;

   // steps per corner run at the end
   localparam int SAT_STEPS   = 55;
   // items per random phase; six phases, the directed part and the two corner
   // runs give about 1150 items
   localparam int PHASE_STEPS = 170;
   // cycles let pass after the last result before touching the registers
   localparam int SETTLE      = 8;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_payload_type       req_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  rsp_valid;
   rsp_payload_type       rsp_data;
   int                    fail_count;
   int                    outstanding;

   gridworld_q_learning_step_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   gqls_step_checker step_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // 12 ns period
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Wait out the `idle` gap with start low, then hold one step request until the
   // transfer edge. start stays high afterwards so that a back-to-back request
   // only changes the data; the next call or a drain drops it.
   task automatic issue_step(input logic [FRAC_IN_W-1:0] frac,
                             input logic [ACT_W-1:0] act, input int idle);
      if (idle > 0) begin
         start <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_data <= '{rand_fraction: frac, rand_action: act};
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Stop sending and wait until every predicted step has come back, then let
   // the pipeline settle. Sampled on the falling edge so the checker's update
   // at the rising edge is already done.
   task automatic drain_steps();
      start <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // one register transfer; valid stays high for back-to-back writes
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Full register set, written only once the core is idle. Unused upper data
   // bits carry junk that the core must drop; an unmapped index is hit too.
   task automatic apply_settings(input logic [1:0] s_row, input logic [2:0] s_col,
                                 input logic [1:0] g_row, input logic [2:0] g_col,
                                 input logic [7:0] g_rew, input logic [7:0] w_rew,
                                 input logic [2:0] a_sh, input logic [2:0] g_sh);
      drain_steps();
      write_reg(CSR_IDX_W'(8 + $urandom_range(0, 7)), 8'($urandom));
      write_reg(REG_START_ROW, {6'($urandom), s_row});
      write_reg(REG_START_COL, {5'($urandom), s_col});
      write_reg(REG_GOAL_ROW, {6'($urandom), g_row});
      write_reg(REG_GOAL_COL, {5'($urandom), g_col});
      write_reg(REG_GOAL_REWARD, g_rew);
      write_reg(REG_WALL_REWARD, w_rew);
      write_reg(REG_ALPHA_SHIFT, {5'($urandom), a_sh});
      write_reg(REG_GAMMA_SHIFT, {5'($urandom), g_sh});
      csr_valid <= 1'b0;
   endtask

   // Random steps. The fraction mixes small values (explore), all ones (greedy
   // once the cell was seen twice) and values near 1/count, where the explore
   // test flips. Bursts with no gaps alternate with gapped stretches.
   task automatic run_random(input int count);
      int                   idle;
      bit                   burst;
      logic [FRAC_IN_W-1:0] frac;
      for (int n = 0; n < count; n++) begin
         if (n % 32 == 0)
            burst = ($urandom_range(0, 3) == 0);
         // now and then let the core run completely dry
         if ($urandom_range(0, 59) == 0)
            drain_steps();
         idle = burst ? 0 : $urandom_range(0, 13);
         case ($urandom_range(0, 4))
            0:       frac = 16'($urandom_range(0, 255));
            1:       frac = 16'hFFFF;
            2:       frac = 16'((65536 / $urandom_range(2, 40)) - 1 + $urandom_range(0, 2));
            default: frac = 16'($urandom);
         endcase
         issue_step(frac, ACT_W'($urandom), idle);
      end
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // --- directed: reset settings, start (2,1), goal (1,4) on the right edge
      issue_step(16'h0000, ACT_UP, 0);      // unvisited cell explores
      issue_step(16'hFFFF, ACT_RIGHT, 0);
      issue_step(16'hFFFF, ACT_RIGHT, 2);
      issue_step(16'h0000, ACT_RIGHT, 0);   // lands on the goal
      issue_step(16'hFFFF, ACT_LEFT, 0);    // count one: full fraction still explores
      issue_step(16'hFFFF, ACT_DOWN, 1);    // greedy, a tie for the best Q picks the lowest action
      issue_step(16'h8000, ACT_DOWN, 0);

      // start in a corner: moves off the grid stop at the edge and count as a wall
      apply_settings(2'd0, 3'd0, 2'd0, 3'd4, 8'h7F, 8'h80, 3'd0, 3'd7);
      issue_step(16'h0000, ACT_UP, 0);
      issue_step(16'h0000, ACT_UP, 0);
      issue_step(16'h0000, ACT_UP, 0);
      issue_step(16'h0000, ACT_LEFT, 0);
      issue_step(16'h0000, ACT_DOWN, 3);
      issue_step(16'h0000, ACT_RIGHT, 0);
      issue_step(16'hFFFF, ACT_UP, 0);

      // start column out of range is clipped; goal column out of range is never hit
      apply_settings(2'd3, 3'd7, 2'd3, 3'd6, 8'h80, 8'h7F, 3'd7, 3'd0);
      issue_step(16'h0000, ACT_DOWN, 0);
      issue_step(16'h0000, ACT_DOWN, 0);
      issue_step(16'h0000, ACT_DOWN, 0);
      issue_step(16'h0000, ACT_RIGHT, 0);
      issue_step(16'hFFFF, ACT_LEFT, 0);

      // goal on the bottom edge next to the start: goal takes precedence over wall
      apply_settings(2'd3, 3'd4, 2'd3, 3'd3, 8'h7F, 8'h80, 3'd3, 3'd2);
      issue_step(16'h0000, ACT_LEFT, 0);
      issue_step(16'h0000, ACT_LEFT, 0);
      issue_step(16'hFFFF, ACT_UP, 0);

      // --- random phases: three fixed register sets (the reset values, then two with the
      // shift extremes), then random ones (start and goal columns sometimes out of range)
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0:       apply_settings(START_ROW_RST, START_COL_RST, GOAL_ROW_RST, GOAL_COL_RST,
                                    GOAL_REWARD_RST, WALL_REWARD_RST,
                                    ALPHA_SHIFT_RST, GAMMA_SHIFT_RST);
            1:       apply_settings(2'd1, 3'd1, 2'd2, 3'd3, 8'h7F, 8'h80, 3'd0, 3'd0);
            2:       apply_settings(2'd2, 3'd3, 2'd1, 3'd1, 8'h80, 8'h7F, 3'd7, 3'd7);
            default: apply_settings(2'($urandom), 3'($urandom_range(0, 5)),
                                    2'($urandom), 3'($urandom_range(0, 6)),
                                    8'($urandom), 8'($urandom),
                                    3'($urandom), 3'($urandom));
         endcase
         run_random(PHASE_STEPS);
      end

      // --- corner runs: start and goal both in the top-left corner. Up or left
      // stays there and reaches the goal every step, so the goal counter, the
      // corner's visit count and its Q values (no shift) climb back to back.
      apply_settings(2'd0, 3'd0, 2'd0, 3'd0, 8'h7F, 8'h80, 3'd0, 3'd0);
      for (int n = 0; n < SAT_STEPS; n++) begin
         if (n < 4)
            issue_step(16'h0000, ACT_UP, 0);   // climb to row 0 from wherever
         else
            issue_step(16'($urandom), $urandom_range(0, 1) ? ACT_UP : ACT_LEFT, 0);
      end

      // goal moved off the grid: every move from the corner is now a wall
      apply_settings(2'd0, 3'd0, 2'd0, 3'd7, 8'($urandom), 8'h80,
                     3'($urandom), 3'($urandom));
      for (int n = 0; n < SAT_STEPS; n++)
         issue_step(16'($urandom), ACT_W'($urandom), 0);

      drain_steps();
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog: 60 ms, far longer than the slowest legal run
   initial begin
      #(60_000_000);
      $display("Mismatches found");
      $finish;
   end

endmodule

### sim.f
rtl/gqls_pkg.sv
rtl/gqls_ctrl.sv
rtl/gqls_datapath.sv
rtl/gridworld_q_learning_step_core.sv
rtl/gqls_checker.sv
tb/gqls_step_checker.sv
tb/testbench.sv
